>>> rtl/core/crarc_pkg.sv
// Shared types and constants for the credit receiver ack and rate control block.
// No dependencies; used by every module in rtl/core.

package crarc_pkg;

	localparam int SEQ_W      = 48;
	localparam int RATE_W     = 20;
	localparam int FRAC_W     = 16;
	localparam int CNT_W      = 32;
	localparam int TIME_W     = 63;
	localparam int RTT_W      = 48;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	localparam int REORDER_DEPTH_DEF = 16;

	// shared divider: numerator and divisor widths
	localparam int DIV_NW = 49;
	localparam int DIV_DW = 32;

	localparam logic [RATE_W-1:0] MAX_RATE_RST  = 20'd95000;
	localparam logic [RATE_W-1:0] MIN_RATE_RST  = 20'd100;
	localparam logic [RATE_W-1:0] INIT_RATE_RST = 20'd95000;
	localparam logic [FRAC_W-1:0] TGT_LOSS_RST  = 16'd6554;
	localparam logic [FRAC_W-1:0] MAX_W_RST     = 16'd32768;
	localparam logic [FRAC_W-1:0] MIN_W_RST     = 16'd655;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_RATE     = 3'd0,
		REG_MIN_RATE     = 3'd1,
		REG_INITIAL_RATE = 3'd2,
		REG_TARGET_LOSS  = 3'd3,
		REG_MAX_WEIGHT   = 3'd4,
		REG_MIN_WEIGHT   = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		CELL_HOLD = 2'd0,
		CELL_INS  = 2'd1,
		CELL_POP  = 2'd2
	} cell_op_t;

	typedef struct packed {
		cell_op_t           op;
		logic [SEQ_W-1:0]   key;
	} cell_ctl_t;

	typedef struct packed {
		logic [SEQ_W-1:0]  seq_first_byte;
		logic [15:0]       payload_bytes;
		logic [CNT_W-1:0]  credit_number;
		logic              is_last;
		logic [TIME_W-1:0] send_time;
		logic [TIME_W-1:0] arrival_time;
	} in_item_t;

	typedef struct packed {
		logic [SEQ_W-1:0]  ack_number;
		logic [CNT_W-1:0]  lost_packets;
		logic [RATE_W-1:0] credit_rate;
		logic [RTT_W-1:0]  rtt_estimate;
		logic              begin_pulling;
		logic              flow_complete;
		logic              reorder_overflow;
	} out_item_t;

endpackage

>>> rtl/core/crarc_cell.sv
// One slot of the sorted reorder row: holds a sequence number, compares it with the key
// and shifts right on insert or left on pop. Depends on crarc_pkg.

module crarc_cell #(
	parameter int DEPTH = crarc_pkg::REORDER_DEPTH_DEF,
	parameter int IDX   = 0
) (
	input  logic                              clk,
	input  crarc_pkg::cell_ctl_t              ctl,
	input  logic [$clog2(DEPTH+1)-1:0]        count,
	input  logic [crarc_pkg::SEQ_W-1:0]       left_val,
	input  logic                              left_lt,
	input  logic [crarc_pkg::SEQ_W-1:0]       right_val,
	output logic [crarc_pkg::SEQ_W-1:0]       val,
	output logic                              lt,
	output logic                              eq
);
	import crarc_pkg::*;

	localparam int CW = $clog2(DEPTH+1);
	localparam logic [CW-1:0] IDX_C = CW'(IDX);

	logic [SEQ_W-1:0] val_q;
	logic             valid;
	logic             at_end;

	assign valid  = count > IDX_C;
	assign at_end = count == IDX_C;
	assign lt     = valid && (ctl.key < val_q);
	assign eq     = valid && (ctl.key == val_q);
	assign val    = val_q;

	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_INS: begin
				if (valid || at_end) begin
					if (left_lt)
						val_q <= left_val;
					else if (lt || at_end)
						val_q <= ctl.key;
				end
			end
			CELL_POP: begin
				val_q <= right_val;
			end
			default: begin
			end
		endcase
	end

endmodule

>>> rtl/core/crarc_div.sv
// Restoring divider, one quotient bit per cycle, shared by all divisions of the block.
// Depends on crarc_pkg.

module crarc_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [crarc_pkg::DIV_NW-1:0]       numer,
	input  logic [crarc_pkg::DIV_DW-1:0]       denom,
	output logic                               busy,
	output logic                               done,
	output logic [crarc_pkg::DIV_NW-1:0]       quot
);
	import crarc_pkg::*;

	localparam int IW = $clog2(DIV_NW+1);

	logic [DIV_NW-1:0] n_q;
	logic [DIV_DW-1:0] d_q;
	logic [DIV_DW-1:0] r_q;
	logic [IW-1:0]     cnt_q;
	logic              run_q;
	logic              done_q;
	logic [DIV_DW:0]   r_sh;
	logic              qbit;

	assign r_sh = {r_q, n_q[DIV_NW-1]};
	assign qbit = r_sh >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= IW'(DIV_NW);
			end else if (run_q) begin
				cnt_q <= cnt_q - IW'(1);
				if (cnt_q == IW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= numer;
			d_q <= denom;
			r_q <= '0;
		end else if (run_q) begin
			n_q <= {n_q[DIV_NW-2:0], qbit};
			r_q <= qbit ? DIV_DW'(r_sh - {1'b0, d_q}) : r_sh[DIV_DW-1:0];
		end
	end

	assign busy = run_q;
	assign done = done_q;
	assign quot = n_q;

endmodule

>>> rtl/core/credit_receiver_ack_rate_control_unit.sv
// Top level of the credit receiver ack and rate control block.
// Depends on crarc_pkg, crarc_cell and crarc_div.
//
// Usage: one request on in_valid/in_ready per arriving data packet; one result on
// out_valid/out_ready per request, in order. Registers are to be written on the cfg
// channel (cfg_ready is always high) only while no request is in flight; the block
// does not enforce this. States from accept to out_valid: S_UPD; S_POP for an in-order
// packet, popping each stored entry that extends the ack; S_LDIV, waiting on the
// shared divider for the lost-packet estimate when a gap opens on an empty row;
// S_FBCHK; if feedback runs, S_TDIV when the rate is below a nonzero max rate, then
// S_LDV2, S_MUL1 and S_MUL2; last S_OUT. One packet is in work at a time; the next
// request can be taken in the cycle after the previous result is registered.
// The result sits in an output register, so the next request is taken while the
// previous result still waits; a stalled receiver holds the block in its final state
// only when a second result is ready and the register is still full.
// Reset clears ack, counters, RTT and the reorder fill count, loads default
// registers, sets the rate to the initial rate and the weight to the max weight.

module credit_receiver_ack_rate_control_unit #(
	parameter int REORDER_DEPTH = crarc_pkg::REORDER_DEPTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  crarc_pkg::in_item_t                   in_data,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output crarc_pkg::out_item_t                  out_data,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [crarc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [crarc_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import crarc_pkg::*;

	localparam int CW = $clog2(REORDER_DEPTH+1);

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_UPD   = 10'b0000000010,
		S_POP   = 10'b0000000100,
		S_LDIV  = 10'b0000001000,
		S_FBCHK = 10'b0000010000,
		S_TDIV  = 10'b0000100000,
		S_LDV2  = 10'b0001000000,
		S_MUL1  = 10'b0010000000,
		S_MUL2  = 10'b0100000000,
		S_OUT   = 10'b1000000000
	} state_t;

	state_t state_q;

	// configuration
	logic [RATE_W-1:0] max_rate_q, min_rate_q, init_rate_q;
	logic [FRAC_W-1:0] tgt_loss_q, max_w_q, min_w_q;

	// flow state
	in_item_t          in_q;
	out_item_t         out_q;
	logic              out_valid_q;
	logic [SEQ_W-1:0]  cum_ack_q, final_q;
	logic [SEQ_W-1:0]  br_q;
	logic [CW-1:0]     cnt_q;
	logic [CNT_W-1:0]  last_cn_q, seen_q, lost_q, loss_tot_q;
	logic [RTT_W-1:0]  srtt_q;
	logic [RATE_W-1:0] rate_q;
	logic [FRAC_W-1:0] weight_q;
	logic              incr_q;
	logic [TIME_W-1:0] lft_q;
	logic              begin_q, ovf_q, inc_sel_q;
	logic [FRAC_W-1:0] tgt_q;
	logic [FRAC_W:0]   loss_q;
	logic [36:0]       p1_q;
	logic [35:0]       p2_q;

	// cell row
	cell_ctl_t         cell_ctl;
	logic [SEQ_W-1:0]  cval [REORDER_DEPTH];
	logic              clt  [REORDER_DEPTH];
	logic              ceq  [REORDER_DEPTH];
	logic [REORDER_DEPTH-1:0] eq_vec;
	logic              any_eq;

	for (genvar i = 0; i < REORDER_DEPTH; i++) begin : g_cell
		crarc_cell #(.DEPTH(REORDER_DEPTH), .IDX(i)) u_cell (
			.clk       (clk),
			.ctl       (cell_ctl),
			.count     (cnt_q),
			.left_val  ((i == 0) ? '0 : cval[(i == 0) ? 0 : i-1]),
			.left_lt   ((i == 0) ? 1'b0 : clt[(i == 0) ? 0 : i-1]),
			.right_val (cval[(i == REORDER_DEPTH-1) ? i : i+1]),
			.val       (cval[i]),
			.lt        (clt[i]),
			.eq        (ceq[i])
		);
		assign eq_vec[i] = ceq[i];
	end
	assign any_eq = |eq_vec;

	// divider
	logic              div_start, div_busy, div_done;
	logic [DIV_NW-1:0] div_n, div_q;
	logic [DIV_DW-1:0] div_d;

	crarc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.numer  (div_n),
		.denom  (div_d),
		.busy   (div_busy),
		.done   (div_done),
		.quot   (div_q)
	);

	// per-packet arithmetic
	logic [SEQ_W-1:0]  seq, nxt, seq_end;
	logic [15:0]       psize;
	logic [TIME_W-1:0] d_t, fb_dt;
	logic [RTT_W-1:0]  m_rtt, srtt_new;
	logic [RTT_W+2:0]  srtt7;
	logic [CNT_W-1:0]  cn_gap;
	logic [CNT_W:0]    seen_sum, lost_sum, ltot_sum;
	logic [CNT_W-1:0]  qclip;
	logic [SEQ_W:0]    br_sum;
	logic              full, tgt_on;
	logic [RATE_W-1:0] rate_diff;
	logic [35:0]       tprod;

	assign seq     = in_q.seq_first_byte;
	assign psize   = in_q.payload_bytes;
	assign nxt     = cum_ack_q + SEQ_W'(1);
	assign seq_end = seq + SEQ_W'(psize) - SEQ_W'(1);
	assign d_t     = in_q.arrival_time - in_q.send_time;
	assign m_rtt   = (d_t > TIME_W'(48'h7FFF_FFFF_FFFF)) ? '1 : {d_t[RTT_W-2:0], 1'b0};
	assign srtt7   = {srtt_q, 3'b000} - {3'b000, srtt_q};
	assign srtt_new = (srtt_q != '0) ? (srtt7[RTT_W+2:3] + (m_rtt >> 3)) : m_rtt;
	assign cn_gap  = in_q.credit_number - last_cn_q;
	assign seen_sum = {1'b0, seen_q} + {1'b0, cn_gap};
	assign lost_sum = {1'b0, lost_q} + {1'b0, cn_gap - CNT_W'(1)};
	assign br_sum  = {1'b0, br_q} + (SEQ_W+1)'(psize);
	assign qclip   = (div_q > DIV_NW'(32'hFFFF_FFFF)) ? '1 : div_q[CNT_W-1:0];
	assign ltot_sum = {1'b0, loss_tot_q} + {1'b0, qclip};
	assign full    = cnt_q == CW'(REORDER_DEPTH);
	assign fb_dt   = in_q.arrival_time - lft_q;
	assign tgt_on  = (max_rate_q != '0) && (rate_q < max_rate_q);
	assign rate_diff = max_rate_q - rate_q;
	assign tprod   = tgt_loss_q * rate_diff;

	// feedback arithmetic
	logic [FRAC_W:0]   w_sum;
	logic [FRAC_W-1:0] w_avg, w_sel, w_half;
	logic [FRAC_W:0]   one_m_w, one_m_l, one_p_t;
	logic [37:0]       inc_sum;
	logic [21:0]       inc_r;
	logic [53:0]       dec_prod;
	logic [21:0]       dec_r;

	assign w_sum   = {1'b0, weight_q} + {1'b0, max_w_q};
	assign w_avg   = (w_sum[FRAC_W:1] > max_w_q) ? max_w_q : w_sum[FRAC_W:1];
	assign w_sel   = incr_q ? w_avg : weight_q;
	assign one_m_w = 17'h10000 - {1'b0, w_sel};
	assign one_m_l = 17'h10000 - loss_q;
	assign one_p_t = 17'h10000 + {1'b0, tgt_q};
	assign inc_sum = {1'b0, p1_q} + {2'b00, p2_q} + 38'd32768;
	assign inc_r   = inc_sum[37:16];
	assign dec_prod = p1_q * one_p_t;
	assign dec_r   = 22'((dec_prod + 54'h8000_0000) >> 32);
	assign w_half  = weight_q >> 1;

	always_comb begin
		cell_ctl.op  = CELL_HOLD;
		cell_ctl.key = seq;
		div_start    = 1'b0;
		div_n        = '0;
		div_d        = '0;
		case (state_q)
			S_UPD: begin
				if (seq > nxt && (cnt_q == '0 || (!any_eq && !full)))
					cell_ctl.op = CELL_INS;
				if (seq != nxt && seq > nxt && cnt_q == '0 && psize != '0) begin
					div_start = 1'b1;
					div_n     = DIV_NW'(psize) + {1'b0, seq - nxt};
					div_d     = DIV_DW'(psize);
				end
			end
			S_POP: begin
				if (cnt_q != '0 && cval[0] == nxt)
					cell_ctl.op = CELL_POP;
			end
			S_FBCHK: begin
				if (fb_dt > TIME_W'(srtt_q) && seen_q != '0) begin
					div_start = 1'b1;
					if (tgt_on) begin
						div_n = DIV_NW'(tprod);
						div_d = DIV_DW'(max_rate_q);
					end else begin
						div_n = {1'b0, lost_q, 16'h0000};
						div_d = seen_q;
					end
				end
			end
			S_TDIV: begin
				if (div_done) begin
					div_start = 1'b1;
					div_n     = {1'b0, lost_q, 16'h0000};
					div_d     = seen_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_rate_q  <= MAX_RATE_RST;
			min_rate_q  <= MIN_RATE_RST;
			init_rate_q <= INIT_RATE_RST;
			tgt_loss_q  <= TGT_LOSS_RST;
			max_w_q     <= MAX_W_RST;
			min_w_q     <= MIN_W_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MAX_RATE:     max_rate_q  <= cfg_data;
				REG_MIN_RATE:     min_rate_q  <= cfg_data;
				REG_INITIAL_RATE: init_rate_q <= cfg_data;
				REG_TARGET_LOSS:  tgt_loss_q  <= cfg_data[FRAC_W-1:0];
				REG_MAX_WEIGHT:   max_w_q     <= cfg_data[FRAC_W-1:0];
				REG_MIN_WEIGHT:   min_w_q     <= cfg_data[FRAC_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			cum_ack_q   <= '0;
			final_q     <= '0;
			br_q        <= '0;
			cnt_q       <= '0;
			last_cn_q   <= '0;
			seen_q      <= '0;
			lost_q      <= '0;
			loss_tot_q  <= '0;
			srtt_q      <= '0;
			rate_q      <= INIT_RATE_RST;
			weight_q    <= MAX_W_RST;
			incr_q      <= 1'b1;
			lft_q       <= '0;
			begin_q     <= 1'b0;
			ovf_q       <= 1'b0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= S_UPD;
				end
				S_UPD: begin
					begin_q <= br_q == '0;
					if (br_q == '0) begin
						rate_q   <= init_rate_q;
						weight_q <= max_w_q;
						incr_q   <= 1'b1;
					end
					if (in_q.is_last)
						final_q <= seq_end;
					if (m_rtt != '0)
						srtt_q <= srtt_new;
					if (in_q.credit_number > last_cn_q) begin
						seen_q    <= seen_sum[CNT_W] ? '1 : seen_sum[CNT_W-1:0];
						lost_q    <= lost_sum[CNT_W] ? '1 : lost_sum[CNT_W-1:0];
						last_cn_q <= in_q.credit_number;
					end
					br_q  <= br_sum[SEQ_W] ? '1 : br_sum[SEQ_W-1:0];
					ovf_q <= 1'b0;
					state_q <= S_FBCHK;
					if (seq == nxt) begin
						cum_ack_q <= seq_end;
						state_q   <= S_POP;
					end else if (seq > nxt) begin
						if (cnt_q == '0) begin
							cnt_q <= CW'(1);
							if (psize != '0)
								state_q <= S_LDIV;
						end else if (!any_eq) begin
							if (full)
								ovf_q <= 1'b1;
							else
								cnt_q <= cnt_q + CW'(1);
						end
					end
				end
				S_POP: begin
					if (cnt_q != '0 && cval[0] == nxt) begin
						cnt_q     <= cnt_q - CW'(1);
						cum_ack_q <= cum_ack_q + SEQ_W'(psize);
					end else begin
						state_q <= S_FBCHK;
					end
				end
				S_LDIV: begin
					if (div_done) begin
						loss_tot_q <= ltot_sum[CNT_W] ? '1 : ltot_sum[CNT_W-1:0];
						state_q    <= S_FBCHK;
					end
				end
				S_FBCHK: begin
					state_q <= S_OUT;
					if (fb_dt > TIME_W'(srtt_q)) begin
						lft_q <= in_q.arrival_time;
						if (seen_q != '0) begin
							if (tgt_on) begin
								state_q <= S_TDIV;
							end else begin
								tgt_q   <= '0;
								state_q <= S_LDV2;
							end
						end
					end
				end
				S_TDIV: begin
					if (div_done) begin
						tgt_q   <= div_q[FRAC_W-1:0];
						state_q <= S_LDV2;
					end
				end
				S_LDV2: begin
					if (div_done) begin
						loss_q  <= (div_q > DIV_NW'(17'h10000)) ? 17'h10000 : div_q[FRAC_W:0];
						state_q <= S_MUL1;
					end
				end
				S_MUL1: begin
					inc_sel_q <= {1'b0, loss_q} < {2'b00, tgt_q};
					if ({1'b0, loss_q} < {2'b00, tgt_q}) begin
						weight_q <= w_sel;
						p1_q     <= one_m_w * rate_q;
						p2_q     <= w_sel * max_rate_q;
					end else begin
						p1_q     <= rate_q * one_m_l;
					end
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					if (inc_sel_q) begin
						rate_q <= (inc_r > {2'b00, max_rate_q}) ? max_rate_q : inc_r[RATE_W-1:0];
						incr_q <= 1'b1;
					end else begin
						if (dec_r < {2'b00, min_rate_q})
							rate_q <= min_rate_q;
						else if (dec_r > 22'hF_FFFF)
							rate_q <= '1;
						else
							rate_q <= dec_r[RATE_W-1:0];
						weight_q <= (w_half < min_w_q) ? min_w_q : w_half;
						incr_q   <= 1'b0;
					end
					seen_q  <= '0;
					lost_q  <= '0;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid)
			in_q <= in_data;
		if (state_q == S_OUT && (!out_valid_q || out_ready)) begin
			out_q.ack_number       <= cum_ack_q;
			out_q.lost_packets     <= loss_tot_q;
			out_q.credit_rate      <= rate_q;
			out_q.rtt_estimate     <= srtt_q;
			out_q.begin_pulling    <= begin_q;
			out_q.flow_complete    <= (final_q != '0) && (cum_ack_q == final_q);
			out_q.reorder_overflow <= ovf_q;
		end
	end

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef NO_ASSERTIONS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(REORDER_DEPTH)) else $error("reorder fill count above depth");
	a_accept_upd: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_UPD) else $error("request not processed");
	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy) else $error("divider restarted while busy");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cell_ctl.op == CELL_POP |-> cnt_q != '0) else $error("pop from empty row");
	a_ins_room: assert property (@(posedge clk) disable iff (!arst_n)
		cell_ctl.op == CELL_INS |=> cnt_q == $past(cnt_q) + CW'(1))
		else $error("insert did not grow the row");
`endif

endmodule

>>> sim/tb_credit_receiver_ack_rate_control_unit.sv
// Self-checking testbench for credit_receiver_ack_rate_control_unit.
// Depends on crarc_pkg and the block RTL; packets go through a queue-fed driver,
// results are checked by a monitor against an in-bench model of ack, RTT and rate state.

module tb_credit_receiver_ack_rate_control_unit;
	import crarc_pkg::*;

	localparam logic [63:0] MASK48 = 64'hFFFF_FFFF_FFFF;
	localparam logic [63:0] MASK32 = 64'hFFFF_FFFF;
	localparam int DEPTH = REORDER_DEPTH_DEF;
	localparam int STALL_LIMIT = 50000;

	logic clk = 0;
	logic arst_n;
	logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
	in_item_t in_data;
	out_item_t out_data;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	credit_receiver_ack_rate_control_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// register copies
	logic [63:0] r_max_rate, r_min_rate, r_init_rate, r_tgt_loss, r_max_w, r_min_w;
	// receiver state
	logic [47:0] ack_q;
	logic [47:0] ooo_seq [DEPTH];
	int ooo_n;
	logic [47:0] final_b;
	logic [63:0] bytes_rx, last_cn, cr_seen, cr_lost, loss_tot, srtt, peak;
	logic [63:0] rate_q, wt_q;
	logic incr;
	logic [62:0] last_fb;

	in_item_t pkt_q[$];
	out_item_t result_q[$];
	int errors = 0;
	int gap_left = 0, burst_left = 0, stall_cnt = 0, idle_cycles = 0;

	// generator state
	logic [47:0] g_seq;
	logic [63:0] g_cn;
	logic [62:0] g_now;
	in_item_t miss_q[$];

	function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b, logic [63:0] cap);
		if (b > cap)
			b = cap;
		return (a > cap - b) ? cap : a + b;
	endfunction

	task automatic ooo_insert(int pos, logic [47:0] v);
		for (int i = ooo_n; i > pos; i--)
			ooo_seq[i] = ooo_seq[i-1];
		ooo_seq[pos] = v;
		ooo_n++;
	endtask

	task automatic rate_update();
		logic [63:0] loss, tgt, r;
		tgt = 0;
		if (cr_seen == 0)
			return;
		loss = (cr_lost << 16) / cr_seen;
		if (loss > 65536)
			loss = 65536;
		if (r_max_rate != 0 && rate_q < r_max_rate)
			tgt = r_tgt_loss * (r_max_rate - rate_q) / r_max_rate;
		if (loss < tgt) begin
			if (incr) begin
				wt_q = (wt_q + r_max_w) >> 1;
				if (wt_q > r_max_w)
					wt_q = r_max_w;
			end
			rate_q = ((65536 - wt_q) * rate_q + wt_q * r_max_rate + 32768) >> 16;
			if (rate_q > r_max_rate)
				rate_q = r_max_rate;
			incr = 1;
		end else begin
			r = (rate_q * (65536 - loss) * (65536 + tgt) + (64'd1 << 31)) >> 32;
			if (r < r_min_rate)
				r = r_min_rate;
			if (r > 64'hFFFFF)
				r = 64'hFFFFF;
			rate_q = r;
			wt_q = wt_q >> 1;
			if (wt_q < r_min_w)
				wt_q = r_min_w;
			incr = 0;
		end
		cr_seen = 0;
		cr_lost = 0;
	endtask

	task automatic receive_packet(input in_item_t it, output out_item_t o);
		logic [47:0] seq, nxt;
		logic [63:0] sz, cn_gap, m;
		logic [62:0] d, el;
		logic start, ovf, hit;
		seq = it.seq_first_byte;
		sz = it.payload_bytes;
		ovf = 0;
		start = (bytes_rx == 0);
		if (start) begin
			rate_q = r_init_rate;
			wt_q = r_max_w;
			incr = 1;
		end
		if (it.is_last)
			final_b = seq + sz[47:0] - 48'd1;
		d = it.arrival_time - it.send_time;
		m = (d > (MASK48 >> 1)) ? MASK48 : {1'b0, d} * 2;
		if (m != 0) begin
			if (m > peak)
				peak = m;
			srtt = (srtt > 0) ? (7 * srtt) / 8 + m / 8 : m;
		end
		if (it.credit_number > last_cn) begin
			cn_gap = it.credit_number - last_cn;
			cr_seen = sat_add(cr_seen, cn_gap, MASK32);
			cr_lost = sat_add(cr_lost, cn_gap - 1, MASK32);
			last_cn = it.credit_number;
		end
		bytes_rx = sat_add(bytes_rx, sz, MASK48);
		nxt = ack_q + 48'd1;
		if (seq == nxt) begin
			ack_q = seq + sz[47:0] - 48'd1;
			while (ooo_n > 0 && ooo_seq[0] == ack_q + 48'd1) begin
				for (int i = 0; i < ooo_n - 1; i++)
					ooo_seq[i] = ooo_seq[i+1];
				ooo_n--;
				ack_q = ack_q + sz[47:0];
			end
		end else if (seq > nxt) begin
			if (ooo_n == 0) begin
				ooo_seq[0] = seq;
				ooo_n = 1;
				if (sz != 0)
					loss_tot = sat_add(loss_tot, (sz + {16'd0, seq - nxt}) / sz, MASK32);
			end else if (seq > ooo_seq[ooo_n-1]) begin
				if (ooo_n < DEPTH)
					ooo_insert(ooo_n, seq);
				else
					ovf = 1;
			end else begin
				hit = 0;
				for (int i = 0; i < ooo_n && !hit; i++) begin
					if (seq == ooo_seq[i])
						hit = 1;
					else if (seq < ooo_seq[i]) begin
						if (ooo_n < DEPTH)
							ooo_insert(i, seq);
						else
							ovf = 1;
						hit = 1;
					end
				end
			end
		end
		el = it.arrival_time - last_fb;
		if ({1'b0, el} > srtt) begin
			rate_update();
			last_fb = it.arrival_time;
		end
		o.ack_number = ack_q;
		o.lost_packets = loss_tot[31:0];
		o.credit_rate = rate_q[19:0];
		o.rtt_estimate = srtt[47:0];
		o.begin_pulling = start;
		o.flow_complete = (final_b > 0 && ack_q == final_b);
		o.reorder_overflow = ovf;
	endtask

	// request driver: bursts with random gaps
	always @(posedge clk or negedge arst_n) begin
		out_item_t exp_o;
		if (!arst_n) begin
			in_valid <= 0;
			in_data <= '0;
			gap_left = 0;
			burst_left = 0;
			ack_q = '0;
			ooo_n = 0;
			final_b = '0;
			bytes_rx = '0;
			last_cn = '0;
			cr_seen = '0;
			cr_lost = '0;
			loss_tot = '0;
			srtt = '0;
			peak = '0;
			rate_q = INIT_RATE_RST;
			wt_q = MAX_W_RST;
			incr = 1;
			last_fb = '0;
		end else begin
			if (in_valid && in_ready) begin
				receive_packet(in_data, exp_o);
				result_q.insert(result_q.size(), exp_o);
			end
			if (in_valid && !in_ready) begin
			end else if (gap_left > 0) begin
				gap_left--;
				in_valid <= 0;
			end else if (pkt_q.size() > 0) begin
				in_valid <= 1;
				in_data <= pkt_q[0];
				pkt_q.delete(0);
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 30);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
				end else begin
					burst_left--;
				end
			end else begin
				in_valid <= 0;
			end
		end
	end

	// result monitor, receiver stall pattern, register shadow
	always @(posedge clk) begin
		out_item_t e;
		if (!arst_n) begin
			r_max_rate = MAX_RATE_RST;
			r_min_rate = MIN_RATE_RST;
			r_init_rate = INIT_RATE_RST;
			r_tgt_loss = TGT_LOSS_RST;
			r_max_w = MAX_W_RST;
			r_min_w = MIN_W_RST;
			out_ready <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_MAX_RATE:     r_max_rate = cfg_data;
					REG_MIN_RATE:     r_min_rate = cfg_data;
					REG_INITIAL_RATE: r_init_rate = cfg_data;
					REG_TARGET_LOSS:  r_tgt_loss = cfg_data[15:0];
					REG_MAX_WEIGHT:   r_max_w = cfg_data[15:0];
					REG_MIN_WEIGHT:   r_min_w = cfg_data[15:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (result_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result %p", out_data);
				end else begin
					e = result_q[0];
					result_q.delete(0);
					if (out_data.ack_number !== e.ack_number
						|| out_data.lost_packets !== e.lost_packets
						|| out_data.credit_rate !== e.credit_rate
						|| out_data.rtt_estimate !== e.rtt_estimate
						|| out_data.begin_pulling !== e.begin_pulling
						|| out_data.flow_complete !== e.flow_complete
						|| out_data.reorder_overflow !== e.reorder_overflow) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected %p actual %p", e, out_data);
					end
				end
			end
			stall_cnt++;
			out_ready <= !(stall_cnt[6] && $urandom_range(0, 2) != 0);
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	task automatic cfg_write(cfg_reg_t idx, logic [19:0] v);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic cfg_all(logic [19:0] mx, logic [19:0] mn, logic [19:0] ini,
		logic [15:0] tl, logic [15:0] mxw, logic [15:0] mnw);
		cfg_write(REG_MAX_RATE, mx);
		cfg_write(REG_MIN_RATE, mn);
		cfg_write(REG_INITIAL_RATE, ini);
		cfg_write(REG_TARGET_LOSS, {4'd0, tl});
		cfg_write(REG_MAX_WEIGHT, {4'd0, mxw});
		cfg_write(REG_MIN_WEIGHT, {4'd0, mnw});
		cfg_valid <= 0;
	endtask

	task automatic wait_idle();
		do @(posedge clk); while (pkt_q.size() != 0 || in_valid || result_q.size() != 0);
		repeat (200) @(posedge clk);
	endtask

	function automatic in_item_t mk_pkt(logic [47:0] s, logic [15:0] z, logic l);
		in_item_t it;
		g_now += $urandom_range(1000, 40000);
		g_cn += ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
		it.seq_first_byte = s;
		it.payload_bytes = z;
		it.credit_number = g_cn[31:0];
		it.is_last = l;
		it.arrival_time = g_now;
		it.send_time = ($urandom_range(0, 30) == 0) ? g_now : g_now - $urandom_range(2000, 300000);
		return it;
	endfunction

	function automatic in_item_t mk_noise(logic [15:0] z);
		in_item_t it;
		it.seq_first_byte = ($urandom_range(0, 40) == 0) ? 48'({$urandom, $urandom})
			: g_seq - z * $urandom_range(0, 5);
		it.payload_bytes = 16'($urandom_range(1, 65535));
		it.credit_number = $urandom;
		it.is_last = 1'($urandom_range(0, 1));
		it.send_time = 63'({$urandom, $urandom});
		it.arrival_time = 63'({$urandom, $urandom});
		return it;
	endfunction

	task automatic gen_flow(int n, logic [15:0] sz);
		in_item_t win[$];
		in_item_t tmp;
		int k, a, b;
		g_seq = ack_q + 48'd1;
		g_cn = last_cn;
		for (int cnt = 0; cnt < n; ) begin
			k = $urandom_range(0, 99);
			if (k < 6) begin
				pkt_q.insert(pkt_q.size(), mk_noise(sz));
				cnt++;
			end else if (k < 12 && miss_q.size() > 0) begin
				pkt_q.insert(pkt_q.size(), miss_q[0]);
				miss_q.delete(0);
				cnt++;
			end else begin
				k = $urandom_range(1, 5);
				win.delete();
				for (int i = 0; i < k; i++) begin
					win.insert(win.size(), mk_pkt(g_seq, sz, $urandom_range(0, 60) == 0));
					g_seq += sz;
				end
				for (int i = 0; i < k; i++) begin
					a = $urandom_range(0, k - 1);
					b = $urandom_range(0, k - 1);
					tmp = win[a];
					win[a] = win[b];
					win[b] = tmp;
				end
				if ($urandom_range(0, 6) == 0) begin
					miss_q.insert(miss_q.size(), win[0]);
					win.delete(0);
				end
				cnt += win.size();
				foreach (win[i])
					pkt_q.insert(pkt_q.size(), win[i]);
			end
		end
		while (miss_q.size() > 0) begin
			pkt_q.insert(pkt_q.size(), miss_q[0]);
			miss_q.delete(0);
		end
	endtask

	initial begin
		in_item_t it;
		arst_n = 0;
		cfg_valid = 0;
		cfg_index = '0;
		cfg_data = '0;
		g_now = 63'd1000000;
		g_cn = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		cfg_all(20'd95000, 20'd100, 20'd50000, 16'd6554, 16'd32768, 16'd655);

		// flow start, in order, gap, reorder store filled past depth, dup, old, pop, last
		pkt_q.insert(pkt_q.size(), mk_pkt(48'd1, 16'd1000, 0));
		pkt_q.insert(pkt_q.size(), mk_pkt(48'd1001, 16'd1000, 0));
		for (int i = 0; i < 17; i++)
			pkt_q.insert(pkt_q.size(), mk_pkt(48'd3001 + 48'd1000 * i, 16'd1000, 0));
		pkt_q.insert(pkt_q.size(), mk_pkt(48'd3001, 16'd1000, 0));
		pkt_q.insert(pkt_q.size(), mk_pkt(48'd1, 16'd1000, 0));
		pkt_q.insert(pkt_q.size(), mk_pkt(48'd2001, 16'd1000, 0));
		pkt_q.insert(pkt_q.size(), mk_pkt(48'd19001, 16'd1000, 1));
		// stale credit, send time after arrival time
		it = mk_pkt(48'd20001, 16'd65535, 0);
		it.credit_number = 1;
		it.send_time = it.arrival_time + 63'd5000;
		pkt_q.insert(pkt_q.size(), it);
		wait_idle();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: cfg_all(20'd1000000, 20'd1, 20'd1, 16'hFFFF, 16'hFFFF, 16'd0);
				1: cfg_all(20'd1, 20'd1, 20'd1000000, 16'd0, 16'd0, 16'hFFFF);
				3: cfg_all(20'd95000, 20'd100, 20'd95000, 16'd6554, 16'd32768, 16'd655);
				4: cfg_all(20'd1000000, 20'd1000000, 20'($urandom_range(1, 1000000)),
					16'($urandom), 16'($urandom), 16'($urandom));
				default: cfg_all(20'($urandom_range(1, 1000000)), 20'($urandom_range(1, 5000)),
					20'($urandom_range(1, 1000000)), 16'($urandom), 16'($urandom),
					16'($urandom_range(0, 2000)));
			endcase
			gen_flow(150, (ph % 2 == 0) ? 16'($urandom_range(1, 2000))
				: 16'($urandom_range(1, 65535)));
			wait_idle();
		end

		// extreme credit number and times, last item of the run
		it = mk_pkt(ack_q + 48'd1, 16'hFFFF, 1);
		it.credit_number = 32'hFFFF_FFFF;
		it.arrival_time = {63{1'b1}};
		it.send_time = '0;
		pkt_q.insert(pkt_q.size(), it);
		wait_idle();

		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
